// File: hw/rtl/evm_pkg.sv
// ============================================================================
// evm_pkg
// Shared types, constants and arithmetic helpers of the view matrix block.
// ============================================================================
`default_nettype none

package evm_pkg;

    // Angle in Q4.12 radians times 2^20 / (2 pi) gives a phase in 2^-32 turn.
    localparam logic [31:0] ANG_TO_PHASE = 32'd166886;
    // pi / 2 in Q30.
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [16:0] ONE_Q14      = 17'd16384;

    // Horner steps of the sine (through x^11) and cosine (through x^12) series.
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    // Pipeline depths of the trig unit and of the matrix unit.
    localparam int SC_LAT = 16;
    localparam int BK_LAT = 6;

    localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [COS_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // floor(2^32 / divisor); the quotient estimate is then off by at most one.
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576,
        32'd357913941, 32'd2147483648
    };

    typedef struct packed {
        logic signed [15:0] s1;
        logic signed [15:0] c1;
        logic signed [15:0] s2;
        logic signed [15:0] c2;
        logic signed [15:0] s3;
        logic signed [15:0] c3;
    } trig_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    typedef struct packed {
        trig_t trig;
        pos_t  pos;
    } front_item_t;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] back_x;
        logic signed [15:0] back_y;
        logic signed [15:0] back_z;
    } basis_t;

    typedef struct packed {
        basis_t             basis;
        logic signed [31:0] shift_u;
        logic signed [31:0] shift_v;
        logic signed [31:0] shift_w;
    } view_t;

    // Finishes one Horner step: corrects the reciprocal quotient estimate and
    // forms the next term 1 - y, clamped at zero.
    function automatic logic [30:0] horner_next(
        input logic [31:0] p,
        input logic [31:0] q0,
        input logic [7:0]  d
    );
        logic [39:0] qd;
        logic [39:0] r;
        logic [32:0] q;
        logic [32:0] t;
        qd = q0 * d;
        r  = {8'd0, p} - qd;
        q  = {1'b0, q0} + ((r >= {32'd0, d}) ? 33'd1 : 33'd0);
        t  = {2'b00, ONE_Q30} - q;
        if (q > {2'b00, ONE_Q30}) begin
            return 31'd0;
        end
        return t[30:0];
    endfunction

    // Unsigned Q30 to Q14, rounded half up and capped at one.
    function automatic logic signed [15:0] q30_to_q14(input logic [31:0] v);
        logic [32:0] s;
        logic [16:0] r;
        s = {1'b0, v} + 33'd32768;
        r = s[32:16];
        if (r > ONE_Q14) begin
            r = ONE_Q14;
        end
        return $signed(r[15:0]);
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [20:0] r);
        if (r > 21'sd16384) begin
            return 16'sd16384;
        end
        if (r < -21'sd16384) begin
            return -16'sd16384;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] q28_to_q14(input logic signed [31:0] v);
        logic signed [32:0] s;
        s = {v[31], v} + 33'sd8192;
        return clamp_q14({{2{s[32]}}, s[32:14]});
    endfunction

    function automatic logic signed [15:0] q42_to_q14(input logic signed [47:0] v);
        logic signed [48:0] s;
        s = {v[47], v} + 49'sd134217728;
        return clamp_q14(s[48:28]);
    endfunction

    // Negates a Q30 dot product, rounds half up to Q16 and saturates to 32 bits.
    function automatic logic signed [31:0] shift_sat(input logic signed [49:0] d);
        logic signed [49:0] s;
        logic signed [35:0] r;
        s = 50'sd8192 - d;
        r = s[49:14];
        if (r > 36'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (r < -36'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/evm_fifo.sv
// ============================================================================
// evm_fifo
// Small register queue with first-word fall-through output.
// ============================================================================
`default_nettype none

module evm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/evm_sincos.sv
// ============================================================================
// evm_sincos
// Pipelined fixed-point sine and cosine of a Q4.12 angle, results in Q2.14.
// ============================================================================
`default_nettype none

module evm_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] ang,
    output logic signed [15:0] sin_q14,
    output logic signed [15:0] cos_q14
);

    localparam int NS = evm_pkg::COS_STEPS;
    localparam int SS = evm_pkg::SIN_STEPS;

    logic [31:0] phase_next;
    logic [60:0] x_prod;
    logic [61:0] sq_prod;

    logic [31:0] phase_reg;
    logic [1:0]  quad1_reg;
    logic [30:0] x1_reg;
    logic [1:0]  quad2_reg;
    logic [30:0] x2_reg;
    logic [31:0] sq2_reg;

    // One A stage (series multiply) and one B stage (reciprocal multiply) per step.
    logic [1:0]  a_quad_reg [NS];
    logic [30:0] a_x_reg    [NS];
    logic [31:0] a_sq_reg   [NS-1];
    logic [31:0] a_ps_reg   [NS];
    logic [31:0] a_pc_reg   [NS];
    logic [1:0]  b_quad_reg [NS];
    logic [30:0] b_x_reg    [NS-1];
    logic [31:0] b_sq_reg   [NS-1];
    logic [31:0] b_ps_reg   [NS];
    logic [31:0] b_qs_reg   [SS];
    logic [31:0] b_pc_reg   [NS];
    logic [31:0] b_qc_reg   [NS];

    logic [1:0]  in_quad [NS];
    logic [30:0] in_x    [NS];
    logic [31:0] in_sq   [NS];
    logic [30:0] ts_in   [NS];
    logic [30:0] tc_in   [NS];

    logic [30:0]        tc_last;
    logic signed [15:0] sv;
    logic signed [15:0] cv;

    assign phase_next = {{16{ang[15]}}, ang} * evm_pkg::ANG_TO_PHASE;
    assign x_prod     = phase_reg[29:0] * evm_pkg::HALF_PI_Q30;
    assign sq_prod    = x1_reg * x1_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            phase_reg <= phase_next;
            quad1_reg <= phase_reg[31:30];
            x1_reg    <= x_prod[60:30];
            quad2_reg <= quad1_reg;
            x2_reg    <= x1_reg;
            sq2_reg   <= sq_prod[61:30];
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [62:0] pc_prod;
        logic [63:0] mc_prod;

        if (k == 0) begin : g_first
            assign in_quad[k] = quad2_reg;
            assign in_x[k]    = x2_reg;
            assign in_sq[k]   = sq2_reg;
            assign ts_in[k]   = evm_pkg::ONE_Q30;
            assign tc_in[k]   = evm_pkg::ONE_Q30;
        end
        else begin : g_rest
            assign in_quad[k] = b_quad_reg[k-1];
            assign in_x[k]    = b_x_reg[k-1];
            assign in_sq[k]   = b_sq_reg[k-1];
            assign ts_in[k]   = evm_pkg::horner_next(b_ps_reg[k-1], b_qs_reg[k-1],
                                                     evm_pkg::SIN_DIV[k-1]);
            assign tc_in[k]   = evm_pkg::horner_next(b_pc_reg[k-1], b_qc_reg[k-1],
                                                     evm_pkg::COS_DIV[k-1]);
        end

        assign pc_prod = in_sq[k] * tc_in[k];
        assign mc_prod = a_pc_reg[k] * evm_pkg::COS_RECIP[k];

        always_ff @(posedge clk) begin
            if (en) begin
                a_quad_reg[k] <= in_quad[k];
                a_x_reg[k]    <= in_x[k];
                a_pc_reg[k]   <= pc_prod[61:30];
                b_quad_reg[k] <= a_quad_reg[k];
                b_pc_reg[k]   <= a_pc_reg[k];
                b_qc_reg[k]   <= mc_prod[63:32];
            end
        end

        if (k < NS - 1) begin : g_carry
            always_ff @(posedge clk) begin
                if (en) begin
                    a_sq_reg[k] <= in_sq[k];
                    b_sq_reg[k] <= a_sq_reg[k];
                    b_x_reg[k]  <= a_x_reg[k];
                end
            end
        end

        if (k < SS) begin : g_sin
            logic [62:0] ps_prod;
            logic [63:0] ms_prod;
            assign ps_prod = in_sq[k] * ts_in[k];
            assign ms_prod = a_ps_reg[k] * evm_pkg::SIN_RECIP[k];
            always_ff @(posedge clk) begin
                if (en) begin
                    a_ps_reg[k] <= ps_prod[61:30];
                    b_ps_reg[k] <= a_ps_reg[k];
                    b_qs_reg[k] <= ms_prod[63:32];
                end
            end
        end
        else begin : g_sin_done
            // The sine series is finished here: the last stage forms x * t.
            logic [61:0] sx_prod;
            assign sx_prod = a_x_reg[k] * a_ps_reg[k][30:0];
            always_ff @(posedge clk) begin
                if (en) begin
                    a_ps_reg[k] <= {1'b0, ts_in[k]};
                    b_ps_reg[k] <= {1'b0, sx_prod[60:30]};
                end
            end
        end
    end

    assign tc_last = evm_pkg::horner_next(b_pc_reg[NS-1], b_qc_reg[NS-1],
                                          evm_pkg::COS_DIV[NS-1]);
    assign sv = evm_pkg::q30_to_q14(b_ps_reg[NS-1]);
    assign cv = evm_pkg::q30_to_q14({1'b0, tc_last});

    always_ff @(posedge clk) begin
        if (en) begin
            unique case (b_quad_reg[NS-1])
                2'd0: begin
                    sin_q14 <= sv;
                    cos_q14 <= cv;
                end
                2'd1: begin
                    sin_q14 <= cv;
                    cos_q14 <= -sv;
                end
                2'd2: begin
                    sin_q14 <= -sv;
                    cos_q14 <= -cv;
                end
                default: begin
                    sin_q14 <= -cv;
                    cos_q14 <= sv;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/evm_front.sv
// ============================================================================
// evm_front
// Accepts poses and works out the sine and cosine of the three angles.
// ============================================================================
`default_nettype none

module evm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [15:0]   pitch_angle,
    input  logic signed [15:0]   yaw_angle,
    input  logic signed [15:0]   roll_angle,
    input  evm_pkg::pos_t        pos_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output evm_pkg::front_item_t out_item
);

    localparam int LAT = evm_pkg::SC_LAT;

    logic          en;
    logic [LAT-1:0] valid_reg;
    evm_pkg::pos_t pos_reg [LAT];

    // The whole pipeline holds when its last stage cannot hand over.
    assign en        = !valid_reg[LAT-1] || out_ready;
    assign full      = !en;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], push};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            pos_reg[0] <= pos_in;
            for (int i = 1; i < LAT; i++) begin
                pos_reg[i] <= pos_reg[i-1];
            end
        end
    end

    evm_sincos u_yaw (
        .clk     (clk),
        .en      (en),
        .ang     (yaw_angle),
        .sin_q14 (out_item.trig.s1),
        .cos_q14 (out_item.trig.c1)
    );

    evm_sincos u_pitch (
        .clk     (clk),
        .en      (en),
        .ang     (pitch_angle),
        .sin_q14 (out_item.trig.s2),
        .cos_q14 (out_item.trig.c2)
    );

    evm_sincos u_roll (
        .clk     (clk),
        .en      (en),
        .ang     (roll_angle),
        .sin_q14 (out_item.trig.s3),
        .cos_q14 (out_item.trig.c3)
    );

    assign out_item.pos = pos_reg[LAT-1];

endmodule

`default_nettype wire

// File: hw/rtl/evm_back.sv
// ============================================================================
// evm_back
// Forms the rotation basis and the translations from sines, cosines and position.
// ============================================================================
`default_nettype none

module evm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  evm_pkg::front_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output evm_pkg::view_t       out_item
);

    localparam int LAT = evm_pkg::BK_LAT;

    logic           en;
    logic [LAT-1:0] valid_reg;

    // Stage 1: two-factor products.
    logic signed [31:0] c1c3_reg, s1s2_reg, c1s2_reg, c3s1_reg, c1s3_reg, s1s3_reg;
    logic signed [31:0] c2s3_reg, c2c3_reg, c2s1_reg, c1c2_reg;
    logic signed [15:0] s2_1_reg, s3_1_reg;
    evm_pkg::pos_t      pos1_reg;

    // Stage 2: three-factor sums in Q42.
    logic signed [47:0] u0_reg, u2_reg, v0_reg, v2_reg;
    logic signed [31:0] c2s3_2_reg, c2c3_2_reg, c2s1_2_reg, c1c2_2_reg;
    logic signed [15:0] s2_2_reg;
    evm_pkg::pos_t      pos2_reg;

    // Stages 3 to 6: basis, position products, dot products, translations.
    evm_pkg::basis_t    basis3_reg, basis4_reg, basis5_reg;
    evm_pkg::pos_t      pos3_reg;
    logic signed [47:0] prod_reg [9];
    logic signed [49:0] dot_reg  [3];

    logic signed [47:0] e_c1c3, e_c1s3, e_c3s1, e_s1s3;
    logic signed [47:0] m_s1s2s3, m_c1s2s3, m_c3s1s2, m_c1c3s2;
    logic signed [15:0] b_vec [9];
    logic signed [31:0] p_vec [3];

    assign en        = !valid_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            c1c3_reg <= in_item.trig.c1 * in_item.trig.c3;
            s1s2_reg <= in_item.trig.s1 * in_item.trig.s2;
            c1s2_reg <= in_item.trig.c1 * in_item.trig.s2;
            c3s1_reg <= in_item.trig.c3 * in_item.trig.s1;
            c1s3_reg <= in_item.trig.c1 * in_item.trig.s3;
            s1s3_reg <= in_item.trig.s1 * in_item.trig.s3;
            c2s3_reg <= in_item.trig.c2 * in_item.trig.s3;
            c2c3_reg <= in_item.trig.c2 * in_item.trig.c3;
            c2s1_reg <= in_item.trig.c2 * in_item.trig.s1;
            c1c2_reg <= in_item.trig.c1 * in_item.trig.c2;
            s2_1_reg <= in_item.trig.s2;
            s3_1_reg <= in_item.trig.s3;
            pos1_reg <= in_item.pos;
        end
    end

    always_comb begin
        e_c1c3   = c1c3_reg;
        e_c1s3   = c1s3_reg;
        e_c3s1   = c3s1_reg;
        e_s1s3   = s1s3_reg;
        m_s1s2s3 = s1s2_reg * s3_1_reg;
        m_c1s2s3 = c1s2_reg * s3_1_reg;
        m_c3s1s2 = c3s1_reg * s2_1_reg;
        m_c1c3s2 = c1c3_reg * s2_1_reg;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            u0_reg     <= (e_c1c3 <<< 14) + m_s1s2s3;
            u2_reg     <= m_c1s2s3 - (e_c3s1 <<< 14);
            v0_reg     <= m_c3s1s2 - (e_c1s3 <<< 14);
            v2_reg     <= m_c1c3s2 + (e_s1s3 <<< 14);
            c2s3_2_reg <= c2s3_reg;
            c2c3_2_reg <= c2c3_reg;
            c2s1_2_reg <= c2s1_reg;
            c1c2_2_reg <= c1c2_reg;
            s2_2_reg   <= s2_1_reg;
            pos2_reg   <= pos1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            basis3_reg.right_x <= evm_pkg::q42_to_q14(u0_reg);
            basis3_reg.right_y <= evm_pkg::q28_to_q14(c2s3_2_reg);
            basis3_reg.right_z <= evm_pkg::q42_to_q14(u2_reg);
            basis3_reg.up_x    <= evm_pkg::q42_to_q14(v0_reg);
            basis3_reg.up_y    <= evm_pkg::q28_to_q14(c2c3_2_reg);
            basis3_reg.up_z    <= evm_pkg::q42_to_q14(v2_reg);
            basis3_reg.back_x  <= evm_pkg::q28_to_q14(c2s1_2_reg);
            basis3_reg.back_y  <= -s2_2_reg;
            basis3_reg.back_z  <= evm_pkg::q28_to_q14(c1c2_2_reg);
            pos3_reg           <= pos2_reg;
        end
    end

    assign b_vec[0] = basis3_reg.right_x;
    assign b_vec[1] = basis3_reg.right_y;
    assign b_vec[2] = basis3_reg.right_z;
    assign b_vec[3] = basis3_reg.up_x;
    assign b_vec[4] = basis3_reg.up_y;
    assign b_vec[5] = basis3_reg.up_z;
    assign b_vec[6] = basis3_reg.back_x;
    assign b_vec[7] = basis3_reg.back_y;
    assign b_vec[8] = basis3_reg.back_z;
    assign p_vec[0] = pos3_reg.x;
    assign p_vec[1] = pos3_reg.y;
    assign p_vec[2] = pos3_reg.z;

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= b_vec[i] * p_vec[i % 3];
            end
            basis4_reg <= basis3_reg;
            for (int j = 0; j < 3; j++) begin
                dot_reg[j] <= 50'(prod_reg[3*j]) + 50'(prod_reg[3*j+1])
                              + 50'(prod_reg[3*j+2]);
            end
            basis5_reg        <= basis4_reg;
            out_item.basis    <= basis5_reg;
            out_item.shift_u  <= evm_pkg::shift_sat(dot_reg[0]);
            out_item.shift_v  <= evm_pkg::shift_sat(dot_reg[1]);
            out_item.shift_w  <= evm_pkg::shift_sat(dot_reg[2]);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/euler_view_matrix.sv
// ============================================================================
// euler_view_matrix
// Camera view matrix from yaw, pitch and roll angles (Y-X-Z order) and position.
// ============================================================================
//
//  Channel   Direction  Handshake             Contents
//  --------  ---------  --------------------  ------------------------------------
//  pose      in         push / full           pitch, yaw, roll (Q4.12), pos (Q16.16)
//  view      out        empty / pop           u, v, w basis (Q2.14), shifts (Q16.16)
//
// One item enters per clock cycle while full is low, and one leaves per cycle when
// the consumer pops steadily. An item passes through the trig pipeline, where each
// Horner step of the sine and cosine series costs one series multiply and one
// reciprocal multiply, then through the middle queue and the matrix pipeline before
// it reaches the result queue. Each pipeline stalls as a whole only when its last
// stage holds an item that the queue behind it cannot take; the queues let front
// and back stall on their own. Reset clears the valid bits and queue pointers only;
// no clearing pass is needed.
//
`default_nettype none

module euler_view_matrix #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] roll_angle,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z,
    output logic signed [15:0] back_x,
    output logic signed [15:0] back_y,
    output logic signed [15:0] back_z,
    output logic signed [31:0] shift_u,
    output logic signed [31:0] shift_v,
    output logic signed [31:0] shift_w
);

    localparam int MID_W = $bits(evm_pkg::front_item_t);
    localparam int OUT_W = $bits(evm_pkg::view_t);

    evm_pkg::pos_t        pos_in;
    evm_pkg::front_item_t front_item;
    evm_pkg::front_item_t mid_item;
    evm_pkg::view_t       back_item;
    evm_pkg::view_t       view_item;
    logic                 front_valid;
    logic                 mid_full;
    logic                 mid_empty;
    logic                 back_ready;
    logic                 back_valid;
    logic                 out_full;
    logic [MID_W-1:0]     mid_dout;
    logic [OUT_W-1:0]     out_dout;

    assign pos_in.x = pos_x;
    assign pos_in.y = pos_y;
    assign pos_in.z = pos_z;

    // The front accepts poses and produces the sines and cosines of the angles.
    evm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .roll_angle  (roll_angle),
        .pos_in      (pos_in),
        .out_valid   (front_valid),
        .out_ready   (!mid_full),
        .out_item    (front_item)
    );

    // The middle queue decouples the trig pipeline from the matrix pipeline.
    evm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .full  (mid_full),
        .din   (front_item),
        .pop   (back_ready),
        .empty (mid_empty),
        .dout  (mid_dout)
    );

    assign mid_item = evm_pkg::front_item_t'(mid_dout);

    // The back builds the rotation basis and the translation entries.
    evm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_ready  (back_ready),
        .in_item   (mid_item),
        .out_valid (back_valid),
        .out_ready (!out_full),
        .out_item  (back_item)
    );

    // Finished items wait here until the consumer pops them.
    evm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .full  (out_full),
        .din   (back_item),
        .pop   (pop),
        .empty (empty),
        .dout  (out_dout)
    );

    assign view_item = evm_pkg::view_t'(out_dout);
    assign right_x   = view_item.basis.right_x;
    assign right_y   = view_item.basis.right_y;
    assign right_z   = view_item.basis.right_z;
    assign up_x      = view_item.basis.up_x;
    assign up_y      = view_item.basis.up_y;
    assign up_z      = view_item.basis.up_z;
    assign back_x    = view_item.basis.back_x;
    assign back_y    = view_item.basis.back_y;
    assign back_z    = view_item.basis.back_z;
    assign shift_u   = view_item.shift_u;
    assign shift_v   = view_item.shift_v;
    assign shift_w   = view_item.shift_w;

endmodule

`default_nettype wire
